// File: hdl/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Constants shared by the page frame bitmap allocator: bitmap geometry,
// frame and position widths, and the configuration register indexes.
// ----------------------------------------------------------------------------
package pfba_pkg;

    localparam int MAX_FRAMES  = 1024;
    localparam int RANGE_COUNT = 3;

    localparam int FRAME_SHIFT = 12;
    localparam int FRAME_W     = 20;
    localparam int ADDR_W      = 32;

    localparam int CFG_RANGES  = 3;
    localparam int RANGES_USED = (RANGE_COUNT < CFG_RANGES) ? RANGE_COUNT : CFG_RANGES;
    localparam int RANGE_IDX_W = (RANGES_USED > 1) ? $clog2(RANGES_USED) : 1;

    localparam int SUM_W       = FRAME_W + 2;
    localparam int MAP_WORDS   = (MAX_FRAMES + 31) / 32;
    localparam int WORD_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE0_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE0_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE1_FIRST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE1_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE2_FIRST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE2_END   = 3'd5;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

// File: hdl/page_frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// First-fit 4 KiB page frame allocator over up to three frame ranges, with
// the used bits held in a word-wide bitmap memory.
//
//   channel   direction   signals
//   input     in          i_in_valid, o_in_ready, i_opcode, i_free_address
//   config    in          i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
//   output    out         o_out_valid, i_out_ready, o_frame_address
//
// Every item passes S_LEN, S_BASE and S_POS. An allocate then scans bitmap words in S_SCAN (1 to
// 32, one per cycle), then S_MAP and S_OUT; S_MAP is skipped if no frame is free, S_SCAN too if
// no range holds one. A free does its read-modify-write in S_FCLR, or ends after S_POS if
// ignored. Each item ends in S_IDLE before another is taken. Configuration transfers are taken
// only while idle. Reset clears the bitmap at once through per-word valid bits. A waiting result
// does not block input transfers; an allocate holds in S_OUT until the output register is free.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_opcode,
    input  logic [pfba_pkg::ADDR_W-1:0]     i_free_address,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pfba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfba_pkg::FRAME_W-1:0]    i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [pfba_pkg::ADDR_W-1:0]     o_frame_address
);
    import pfba_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LEN  = 3'd1;
    localparam logic [2:0] S_BASE = 3'd2;
    localparam logic [2:0] S_POS  = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_MAP  = 3'd5;
    localparam logic [2:0] S_FCLR = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]             r_state;
    logic                   r_op;
    logic [FRAME_W-1:0]     r_frame_in;

    logic [FRAME_W-1:0]     r_first [CFG_RANGES];
    logic [FRAME_W-1:0]     r_end   [CFG_RANGES];

    logic [FRAME_W-1:0]     r_len   [RANGES_USED];
    logic [FRAME_W-1:0]     r_foff  [RANGES_USED];
    logic [RANGES_USED-1:0] r_match;
    logic [SUM_W-1:0]       r_base  [RANGES_USED];
    logic [SUM_W-1:0]       r_bend  [RANGES_USED];
    logic [SUM_W-1:0]       r_total;
    logic [SUM_W-1:0]       r_last;
    logic [SUM_W-1:0]       r_pos;
    logic [WORD_W-1:0]      r_cword;
    logic [FRAME_W-1:0]     r_sel_first;
    logic [FRAME_W-1:0]     r_off;

    logic                   r_out_valid;
    logic [ADDR_W-1:0]      r_out_addr;

    logic [31:0]            r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0]   r_row_valid;
    logic [31:0]            r_rdata;
    logic                   r_rd_vld;

    logic                   mem_re;
    logic [WORD_W-1:0]      mem_raddr;
    logic                   mem_we;
    logic [WORD_W-1:0]      mem_waddr;
    logic [31:0]            mem_wdata;

    logic [31:0]            eff_word;
    logic [31:0]            scan_mask;
    logic [31:0]            free_bits;
    logic                   scan_hit;
    logic [4:0]             scan_idx;
    logic                   scan_last;

    logic                   free_hit;
    logic [SUM_W-1:0]       free_pos;
    logic                   free_ok;

    logic [RANGE_IDX_W-1:0] map_sel;
    logic                   out_free;
    logic                   out_load;

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_frame_address = r_out_addr;
    assign out_free        = !r_out_valid || i_out_ready;
    assign out_load        = (r_state == S_OUT) && out_free;

    assign eff_word  = r_rd_vld ? r_rdata : 32'd0;
    assign scan_last = ((SUM_W-5)'(r_cword) == r_last[SUM_W-1:5]);

    always_comb begin
        if ((SUM_W-5)'(r_cword) < r_last[SUM_W-1:5]) begin
            scan_mask = 32'hFFFF_FFFF;
        end else begin
            scan_mask = 32'hFFFF_FFFF >> (5'd31 - r_last[4:0]);
        end
        free_bits = ~eff_word & scan_mask;
        scan_hit  = |free_bits;
        scan_idx  = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (free_bits[i]) begin
                scan_idx = 5'(i);
            end
        end
    end

    always_comb begin
        free_hit = 1'b0;
        free_pos = '0;
        for (int r = RANGES_USED - 1; r >= 0; r--) begin
            if (r_match[r]) begin
                free_hit = 1'b1;
                free_pos = r_base[r] + SUM_W'(r_foff[r]);
            end
        end
        free_ok = free_hit && (free_pos < SUM_W'(MAX_FRAMES));
    end

    always_comb begin
        map_sel = '0;
        for (int r = RANGES_USED - 1; r >= 0; r--) begin
            if (r_pos < r_bend[r]) begin
                map_sel = RANGE_IDX_W'(r);
            end
        end
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        case (r_state)
            S_POS: begin
                if (r_op == OP_ALLOC) begin
                    mem_re = (r_total != '0);
                end else begin
                    mem_re    = free_ok;
                    mem_raddr = WORD_W'(free_pos >> 5);
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cword;
                    mem_wdata = eff_word | (32'd1 << scan_idx);
                end else if (!scan_last) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_cword + 1'b1;
                end
            end
            S_FCLR: begin
                mem_we    = 1'b1;
                mem_waddr = WORD_W'(r_pos >> 5);
                mem_wdata = eff_word & ~(32'd1 << r_pos[4:0]);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata  <= r_mem[mem_raddr];
            r_rd_vld <= r_row_valid[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (mem_we) begin
            r_row_valid[mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < CFG_RANGES; r++) begin
                r_first[r] <= '0;
                r_end[r]   <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RANGE0_FIRST: r_first[0] <= i_cfg_data;
                CFG_RANGE0_END:   r_end[0]   <= i_cfg_data;
                CFG_RANGE1_FIRST: r_first[1] <= i_cfg_data;
                CFG_RANGE1_END:   r_end[1]   <= i_cfg_data;
                CFG_RANGE2_FIRST: r_first[2] <= i_cfg_data;
                CFG_RANGE2_END:   r_end[2]   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op       <= i_opcode;
                        r_frame_in <= i_free_address[ADDR_W-1:FRAME_SHIFT];
                        r_state    <= S_LEN;
                    end
                end
                S_LEN: begin
                    for (int r = 0; r < RANGES_USED; r++) begin
                        r_len[r]   <= (r_end[r] > r_first[r]) ? (r_end[r] - r_first[r]) : '0;
                        r_foff[r]  <= r_frame_in - r_first[r];
                        r_match[r] <= (r_frame_in >= r_first[r]) && (r_frame_in < r_end[r]);
                    end
                    r_state <= S_BASE;
                end
                S_BASE: begin
                    logic [SUM_W-1:0] acc;
                    acc = '0;
                    for (int r = 0; r < RANGES_USED; r++) begin
                        r_base[r] <= acc;
                        acc = acc + SUM_W'(r_len[r]);
                        r_bend[r] <= acc;
                    end
                    r_total <= acc;
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_sel_first <= '0;
                    r_off       <= '0;
                    r_cword     <= '0;
                    if (r_total > SUM_W'(MAX_FRAMES)) begin
                        r_last <= SUM_W'(MAX_FRAMES - 1);
                    end else begin
                        r_last <= r_total - 1'b1;
                    end
                    if (r_op == OP_ALLOC) begin
                        r_state <= (r_total != '0) ? S_SCAN : S_OUT;
                    end else begin
                        r_pos   <= free_pos;
                        r_state <= free_ok ? S_FCLR : S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        r_pos   <= SUM_W'({r_cword, scan_idx});
                        r_state <= S_MAP;
                    end else if (scan_last) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cword <= r_cword + 1'b1;
                    end
                end
                S_MAP: begin
                    r_sel_first <= r_first[map_sel];
                    r_off       <= FRAME_W'(r_pos - r_base[map_sel]);
                    r_state     <= S_OUT;
                end
                S_FCLR: begin
                    r_state <= S_IDLE;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_addr  <= {r_sel_first + r_off, {FRAME_SHIFT{1'b0}}};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
